>>> sv/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the glob wildcard matcher
// Request and result layouts, mode codes, pattern symbols and the command
// that is broadcast along the cell chain.
// ----------------------------------------------------------------------------
package gwm_pkg;

  // Width of the pattern length register
  localparam int unsigned LEN_W = 6;

  // Request modes
  localparam logic [1:0] MODE_PATTERN = 2'd0;
  localparam logic [1:0] MODE_NAME    = 2'd1;
  localparam logic [1:0] MODE_END     = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  // Pattern symbols
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_byte;
  } in_req_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_res_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic       load;     // write char_byte into the cell at the current length
    logic       step;     // advance the automaton by one name byte
    logic       restart;  // back to only position zero active
    logic [7:0] char_byte;
  } cell_cmd_t;

endpackage

>>> sv/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of the matcher
// Holds one pattern byte and the active bit of its position, closes over a
// star from the left neighbour and hands closure and match to the right.
// ----------------------------------------------------------------------------
module gwm_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gwm_pkg::cell_cmd_t            cmd_i,
  input  logic [gwm_pkg::LEN_W-1:0]     len_i,
  input  logic                          clos_i,
  input  logic                          shift_i,
  output logic                          clos_o,
  output logic                          shift_o,
  output logic                          closed_o
);

  localparam logic [gwm_pkg::LEN_W-1:0] IdxL = gwm_pkg::LEN_W'(CELL_IDX);
  localparam logic                      ActRst = (CELL_IDX == 0);

  logic [7:0] char_q;
  logic       act_q, act_d;
  logic       used;
  logic       is_star;
  logic       hit;

  assign used    = (len_i > IdxL);
  assign is_star = used && (char_q == gwm_pkg::CH_STAR);
  // a star takes only the else branch: it never moves a position on
  assign hit     = used && !is_star &&
                   ((char_q == gwm_pkg::CH_ANY) || (char_q == cmd_i.char_byte));

  assign closed_o = act_q | clos_i;
  assign clos_o   = closed_o & is_star;
  assign shift_o  = closed_o & hit;

  always_comb begin
    act_d = act_q;
    if (cmd_i.restart) begin
      act_d = ActRst;
    end else if (cmd_i.step) begin
      act_d = shift_i | (closed_o & is_star);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ActRst;
    end else begin
      act_q <= act_d;
    end
  end

  // pattern byte: payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (len_i == IdxL)) begin
      char_q <= cmd_i.char_byte;
    end
  end

endmodule

>>> sv/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher: streaming glob matcher over a row of pattern cells
// Pattern bytes load into the cells; name bytes step the automaton.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_req_i) carries one request per
//   accepted cycle: append pattern byte, name byte, end of name, or clear.
//   Only an end-of-name request produces a result on the output channel
//   (out_valid_o/out_ready_i, out_res_o): matched and pattern_overflow.
//   '*' matches any run of bytes, '?' exactly one, other bytes themselves;
//   the whole name must match the whole pattern.
//   Throughput: one request per cycle, every kind of request, if not stalled.
//   Latency: the result is shown in the cycle after its end-of-name request.
//   Cycle time is set by the star closure, which ripples along the row of
//   PATTERN_MAX cells like a carry chain.
//   Stall: a held result blocks the input only while out_ready_i is low;
//   otherwise the next request is taken in the same cycle as the drain.
//   Reset: empty pattern, overflow clear, only position zero active, no
//   result pending. Pattern bytes past PATTERN_MAX are dropped and flagged.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
  parameter int unsigned PATTERN_MAX = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gwm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gwm_pkg::out_res_t out_res_o
);

  localparam int unsigned IdxW = (PATTERN_MAX < 2) ? 1 : $clog2(PATTERN_MAX + 1);
  localparam logic [gwm_pkg::LEN_W-1:0] LenMax = gwm_pkg::LEN_W'(PATTERN_MAX);

  logic                      accept;
  logic                      room;
  gwm_pkg::cell_cmd_t        cmd;
  logic [gwm_pkg::LEN_W-1:0] len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic                      last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  gwm_pkg::out_res_t         res_q;
  logic                      is_pat, is_name, is_end, is_clear;

  logic [PATTERN_MAX:0]      clos;
  logic [PATTERN_MAX:0]      shift;
  logic [PATTERN_MAX:0]      closed;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (len_q < LenMax);

  always_comb begin
    is_pat   = 1'b0;
    is_name  = 1'b0;
    is_end   = 1'b0;
    is_clear = 1'b0;
    case (in_req_i.mode)
      gwm_pkg::MODE_PATTERN: is_pat   = 1'b1;
      gwm_pkg::MODE_NAME:    is_name  = 1'b1;
      gwm_pkg::MODE_END:     is_end   = 1'b1;
      gwm_pkg::MODE_CLEAR:   is_clear = 1'b1;
      default:               is_clear = 1'b0;
    endcase
  end

  always_comb begin
    cmd.load      = accept && is_pat && room;
    cmd.step      = accept && is_name;
    cmd.restart   = accept && (is_end || is_clear);
    cmd.char_byte = in_req_i.char_byte;
  end

  assign clos[0]  = 1'b0;
  assign shift[0] = 1'b0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    gwm_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .len_i    (len_q),
      .clos_i   (clos[i]),
      .shift_i  (shift[i]),
      .clos_o   (clos[i+1]),
      .shift_o  (shift[i+1]),
      .closed_o (closed[i])
    );
  end

  // terminal position: reached only when the pattern is full, holds no byte
  assign closed[PATTERN_MAX] = last_q | clos[PATTERN_MAX];

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      if (is_clear) begin
        len_d = '0;
        ovf_d = 1'b0;
      end
      if (is_pat) begin
        if (room) begin
          len_d = len_q + gwm_pkg::LEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      if (is_name) begin
        last_d = shift[PATTERN_MAX];
      end
      if (is_end || is_clear) begin
        last_d = 1'b0;
      end
      if (is_end) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture the verdict: closed bit at the pattern length
  always_ff @(posedge clk_i) begin
    if (accept && is_end) begin
      res_q.matched          <= closed[len_q[IdxW-1:0]];
      res_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> sv/gwm_checker.sv
// ----------------------------------------------------------------------------
// gwm_checker: port-level checks for the glob wildcard matcher
// Watches the request and result channels; checks result timing and stall hold.
// ----------------------------------------------------------------------------
module gwm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input gwm_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gwm_pkg::out_res_t out_res_o
);

  logic acc_end;
  logic acc_clear;

  assign acc_end   = in_valid_i && in_ready_o && (in_req_i.mode == gwm_pkg::MODE_END);
  assign acc_clear = in_valid_i && in_ready_o && (in_req_i.mode == gwm_pkg::MODE_CLEAR);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed or vanished while stalled");

  // every end-of-name request gives a result in the next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_end |=> out_valid_o)
    else $error("no result after end of name");

  // a fresh result comes only from an end-of-name request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(acc_end))
    else $error("result without end of name");

  // clear then end: empty pattern matches the empty name, no overflow
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_clear ##1 acc_end |=> out_res_o.matched && !out_res_o.pattern_overflow)
    else $error("empty pattern verdict wrong");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);
